// ===== design/ndmf_pkg.sv =====
// ndmf_pkg: shared constants and codes for the null-delimited message framer.
// Used by null_delimited_message_framer_top. No dependencies.
`default_nettype none

package ndmf_pkg;

  // Default parameter values
  localparam int unsigned DEF_LINE_DEPTH    = 256;
  localparam int unsigned DEF_DISPLAY_CHARS = 30;

  // Printable range and delimiter
  localparam logic [7:0] DELIM_BYTE = 8'h00;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;

  // Register reset values
  localparam logic [31:0] RESET_TIMEOUT = 32'd2000000;
  localparam logic [31:0] RESET_PERIOD  = 32'd500000;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_PERIOD  = 1'b1;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result kinds
  localparam logic RES_CHAR    = 1'b0;
  localparam logic RES_TIMEOUT = 1'b1;

endpackage : ndmf_pkg

`default_nettype wire

// ===== design/null_delimited_message_framer_top.sv =====
// null_delimited_message_framer_top: line assembler with timeout check.
// Depends on ndmf_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid_i / in_stall_o): one transfer is one item, either
//   a received byte (kind 0) or a time tick (kind 1), with its timestamp.
//   Output channel (out_valid_o / out_stall_i): one transfer is one result,
//   a message character or a timeout event.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; write only
//   while the block is idle. Index 0 = timeout_us, 1 = check_period_us.
// Sequencing
//   A non-zero byte is absorbed in its accept cycle: one item per cycle.
//   A tick makes one pass through the shared subtract-compare unit when no
//   check is due and two passes when it is, plus an output load for a
//   timeout result.
//   A delimiter ending a line reads the line store one entry at a time
//   (registered read, then output load) for each of the N characters
//   shown, N at most DISPLAY_CHARS-1.
//   in_stall_o is high while the sequencer is busy.
// Reset
//   Clears fill count, timestamps, message count and loads the register
//   defaults. The line store is not cleared; only written entries reach the output.
// Receiver stall
//   The output register holds its result; the sequencer waits to load the
//   next one, so the input side stalls in turn.
module null_delimited_message_framer_top
  import ndmf_pkg::*;
#(
  parameter int unsigned LINE_DEPTH    = DEF_LINE_DEPTH,
  parameter int unsigned DISPLAY_CHARS = DEF_DISPLAY_CHARS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] now_us_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [7:0]       char_out_o,
  output logic             is_last_o,
  output logic [31:0]      messages_seen_o,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(LINE_DEPTH);     // store address / fill width
  localparam int unsigned SW = $clog2(DISPLAY_CHARS);  // shown-count width
  localparam logic [IW-1:0] FILL_MAX  = IW'(LINE_DEPTH - 1);
  localparam logic [SW-1:0] SHOWN_MAX = SW'(DISPLAY_CHARS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;  // check-period compare
  localparam logic [2:0] ST_TMO  = 3'd2;  // timeout compare
  localparam logic [2:0] ST_RD   = 3'd3;  // issue line store read
  localparam logic [2:0] ST_EMIT = 3'd4;  // load output register

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] fill_q, fill_d;
  logic [31:0]   last_msg_q, last_msg_d;
  logic [31:0]   last_chk_q, last_chk_d;
  logic [31:0]   total_q, total_d;
  logic [31:0]   timeout_q, period_q;
  logic [31:0]   now_q, now_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [SW-1:0] shown_q, shown_d;
  logic          emit_tmo_q, emit_tmo_d;

  logic          out_valid_q;
  logic          out_kind_q;
  logic [7:0]    out_char_q;
  logic          out_last_q;
  logic [31:0]   out_seen_q;

  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we;

  logic          in_xfer, out_xfer, out_free, load_out;
  logic          is_print;

  // shared subtract-compare unit
  logic [31:0]   sub_opnd, sub_lim, sub_diff;
  logic          sub_gt;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == ST_EMIT) && out_free;
  assign cfg_ready_o = 1'b1;

  assign is_print = (rx_byte_i >= PRINT_LOW) && (rx_byte_i <= PRINT_HIGH);
  assign mem_we   = in_xfer && (kind_i == KIND_BYTE) && is_print && (fill_q != FILL_MAX);

  always_comb begin
    if (state_q == ST_TMO) begin
      sub_opnd = last_msg_q;
      sub_lim  = timeout_q;
    end else begin
      sub_opnd = last_chk_q;
      sub_lim  = period_q;
    end
    sub_diff = now_q - sub_opnd;
    sub_gt   = sub_diff > sub_lim;
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    last_msg_d = last_msg_q;
    last_chk_d = last_chk_q;
    total_d    = total_q;
    now_d      = now_q;
    idx_d      = idx_q;
    shown_d    = shown_q;
    emit_tmo_d = emit_tmo_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_TICK) begin
            now_d   = now_us_i;
            state_d = ST_CHK;
          end else if (rx_byte_i == DELIM_BYTE) begin
            if (fill_q != '0) begin
              // clamp to display width
              if (32'(fill_q) > 32'(DISPLAY_CHARS - 1)) begin
                shown_d = SHOWN_MAX;
              end else begin
                shown_d = SW'(fill_q);
              end
              total_d    = total_q + 32'd1;
              last_msg_d = now_us_i;
              fill_d     = '0;
              idx_d      = '0;
              emit_tmo_d = 1'b0;
              state_d    = ST_RD;
            end
          end else if (is_print) begin
            if (fill_q != FILL_MAX) begin
              fill_d = fill_q + IW'(1);
            end else begin
              fill_d = '0;  // line full: drop byte, restart line
            end
          end
        end
      end
      ST_CHK: begin
        if (sub_gt) begin
          last_chk_d = now_q;
          state_d    = ST_TMO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TMO: begin
        if ((last_msg_q != '0) && sub_gt) begin
          last_msg_d = now_q;
          emit_tmo_d = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (emit_tmo_q || (idx_q == shown_q - SW'(1))) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + SW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      last_msg_q  <= '0;
      last_chk_q  <= '0;
      total_q     <= '0;
      timeout_q   <= RESET_TIMEOUT;
      period_q    <= RESET_PERIOD;
      idx_q       <= '0;
      shown_q     <= '0;
      emit_tmo_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      last_msg_q <= last_msg_d;
      last_chk_q <= last_chk_d;
      total_q    <= total_d;
      idx_q      <= idx_d;
      shown_q    <= shown_d;
      emit_tmo_q <= emit_tmo_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          REG_PERIOD:  period_q  <= cfg_data_i;
          default:     timeout_q <= timeout_q;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (load_out) begin
      out_seen_q <= total_q;
      if (emit_tmo_q) begin
        out_kind_q <= RES_TIMEOUT;
        out_char_q <= 8'h00;
        out_last_q <= 1'b1;
      end else begin
        out_kind_q <= RES_CHAR;
        out_char_q <= rd_data_q;
        out_last_q <= (idx_q == shown_q - SW'(1));
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q] <= rx_byte_i;
    end
    rd_data_q <= mem[IW'(idx_q)];
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign char_out_o      = out_char_q;
  assign is_last_o       = out_last_q;
  assign messages_seen_o = out_seen_q;

  // assertions
  a_rd_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_EMIT))
    else $error("read not followed by output load");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (idx_q < shown_q))
    else $error("line store read beyond shown count");

  a_tmo_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == RES_TIMEOUT)) |-> ((out_char_q == 8'h00) && out_last_q))
    else $error("malformed timeout result");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(LINE_DEPTH - 1))
    else $error("fill count beyond line capacity");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && out_stall_i) |=> (state_q == ST_EMIT))
    else $error("sequencer left output load while receiver stalled");

endmodule : null_delimited_message_framer_top

`default_nettype wire

// ===== tb/sv/ndmf_result_checker.sv =====
`timescale 1ns / 1ps
// ndmf_result_checker: watches the item, result and register channels of the
// message framer, predicts every result and compares it field by field.
// Depends on ndmf_pkg.

module ndmf_result_checker
  import ndmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              kind_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       now_us_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              result_kind_i,
  input  logic [7:0]        char_out_i,
  input  logic              is_last_i,
  input  logic [31:0]       messages_seen_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output int unsigned       err_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  chr;
    logic        last;
    logic [31:0] seen;
  } frame_res_t;

  frame_res_t  framed_q [$];

  logic [7:0]  line_mem [DEF_LINE_DEPTH];
  int unsigned fill;
  logic [31:0] last_msg_us;
  logic [31:0] last_check_us;
  logic [31:0] msg_total;
  logic [31:0] timeout_us;
  logic [31:0] period_us;

  // Works out the results of one accepted item and queues them.
  task automatic frame_item(input logic kind, input logic [7:0] b, input logic [31:0] now);
    int unsigned shown;
    frame_res_t  r;
    logic [31:0] since_check;
    logic [31:0] since_msg;
    since_check = now - last_check_us;
    since_msg   = now - last_msg_us;
    if (kind == KIND_BYTE) begin
      if (b == DELIM_BYTE) begin
        if (fill > 0) begin
          shown = (fill > DEF_DISPLAY_CHARS - 1) ? DEF_DISPLAY_CHARS - 1 : fill;
          msg_total   = msg_total + 32'd1;
          last_msg_us = now;
          for (int unsigned i = 0; i < shown; i++) begin
            r.kind = RES_CHAR;
            r.chr  = line_mem[i];
            r.last = (i + 1 == shown);
            r.seen = msg_total;
            framed_q.push_back(r);
          end
          fill = 0;
        end
      end else if (b >= PRINT_LOW && b <= PRINT_HIGH) begin
        // full line: the byte is lost and the line starts over
        if (fill < DEF_LINE_DEPTH - 1) begin
          line_mem[fill] = b;
          fill++;
        end else begin
          fill = 0;
        end
      end
    end else if (since_check > period_us) begin
      last_check_us = now;
      if (last_msg_us != 32'd0 && since_msg > timeout_us) begin
        r.kind = RES_TIMEOUT;
        r.chr  = 8'h00;
        r.last = 1'b1;
        r.seen = msg_total;
        framed_q.push_back(r);
        last_msg_us = now;
      end
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    err_count_o++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  task automatic check_result();
    frame_res_t want;
    if (framed_q.size() == 0) begin
      err_count_o++;
      $display("%0t: unexpected result, expected none, actual kind %0d char %02h last %0d seen %0d",
               $time, result_kind_i, char_out_i, is_last_i, messages_seen_i);
    end else begin
      want = framed_q.pop_front();
      if (result_kind_i !== want.kind) report_field("result_kind", want.kind, result_kind_i);
      if (char_out_i !== want.chr) report_field("char_out", want.chr, char_out_i);
      if (is_last_i !== want.last) report_field("is_last", want.last, is_last_i);
      if (messages_seen_i !== want.seen)
        report_field("messages_seen", want.seen, messages_seen_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill          = 0;
      last_msg_us   = '0;
      last_check_us = '0;
      msg_total     = '0;
      timeout_us    = RESET_TIMEOUT;
      period_us     = RESET_PERIOD;
      framed_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TIMEOUT: timeout_us = cfg_data_i;
          REG_PERIOD:  period_us  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) frame_item(kind_i, rx_byte_i, now_us_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    pending_o = framed_q.size();
  end

endmodule : ndmf_result_checker

// ===== tb/sv/tb_null_delimited_message_framer_top.sv =====
`timescale 1ns / 1ps
// tb_null_delimited_message_framer_top: stimulus, flow control and verdict for
// the message framer. Depends on ndmf_pkg, ndmf_result_checker and the RTL.

module tb_null_delimited_message_framer_top;
  import ndmf_pkg::*;

  // Receiver hold-off length, quiet-cycle watchdog and settle time after
  // the last expected result (a tick with no result still occupies the sequencer).
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        kind      = KIND_BYTE;
  logic [7:0]  rx_byte   = 8'h00;
  logic [31:0] now_us    = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  char_out;
  logic        is_last;
  logic [31:0] messages_seen;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_TIMEOUT;
  logic [31:0] cfg_data  = '0;

  int unsigned err_count;
  int unsigned pending;

  // Flow-control knobs, percent of cycles spent idle / stalled
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go    = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  int unsigned items_sent  = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_us    = '0;

  always #10 clk_i = ~clk_i;

  null_delimited_message_framer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .rx_byte_i      (rx_byte),
    .now_us_i       (now_us),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .char_out_o     (char_out),
    .is_last_o      (is_last),
    .messages_seen_o(messages_seen),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ndmf_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .rx_byte_i      (rx_byte),
    .now_us_i       (now_us),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_i  (result_kind),
    .char_out_i     (char_out),
    .is_last_i      (is_last),
    .messages_seen_i(messages_seen),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  // Receiver: random stalls per phase, plus one long hold-off on request so
  // that the output register and then the input side back up.
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Next timestamp: mostly UART-like spacing, sometimes a long silence,
  // now and then a jump anywhere (wrap and every bit of the field).
  function automatic logic [31:0] next_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) clock_us = clock_us + $urandom_range(20, 200);
    else if (r < 97) clock_us = clock_us + $urandom_range(0, 4000000);
    else clock_us = $urandom;
    return clock_us;
  endfunction

  // One item transfer. The gap, if any, comes first so valid is never
  // lowered and raised in the same step.
  task automatic send_item(input logic k, input logic [7:0] b, input logic [31:0] t);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    now_us   <= t;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Printable characters, closed by a delimiter or left open.
  task automatic send_line(input int unsigned len, input bit closed);
    for (int unsigned n = 0; n < len; n++)
      send_item(KIND_BYTE, 8'($urandom_range(PRINT_HIGH, PRINT_LOW)), next_stamp());
    if (closed) send_item(KIND_BYTE, DELIM_BYTE, next_stamp());
  endtask

  // Drain: wait at the falling edge for the checker to hold nothing, then
  // give a result-free tick time to finish before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers in one burst; valid stays up between the two transfers.
  task automatic configure(input logic [31:0] tmo, input logic [31:0] per);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= tmo;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= REG_PERIOD;
    cfg_data  <= per;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed lines with random text; the rest ticks, stray bytes,
  // bare delimiters and lines left open to run into the next one.
  task automatic random_items(input int unsigned count);
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_line(($urandom_range(3) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12),
                  1'b1);
      else if (pick < 78) send_item(KIND_TICK, 8'($urandom_range(255)), next_stamp());
      else if (pick < 88) send_item(KIND_BYTE, 8'($urandom_range(255)), next_stamp());
      else if (pick < 93) send_item(KIND_BYTE, DELIM_BYTE, next_stamp());
      else send_line($urandom_range(1, 12), 1'b0);
    end
  endtask

  task automatic run_phase(input logic [31:0] tmo, input logic [31:0] per,
                           input int unsigned idle, input int unsigned stall,
                           input bit with_hold, input int unsigned count);
    settle();
    configure(tmo, per);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (with_hold) hold_go <= 1'b1;
    random_items(count);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    configure(RESET_TIMEOUT, RESET_PERIOD);

    // Directed: tick before any message, empty line, ignored bytes
    send_item(KIND_TICK, 8'hAA, 32'd1);
    send_item(KIND_BYTE, DELIM_BYTE, 32'd10);
    send_item(KIND_BYTE, 8'h01, 32'd20);
    send_item(KIND_BYTE, 8'h1F, 32'd21);
    send_item(KIND_BYTE, 8'h7F, 32'd22);
    send_item(KIND_BYTE, 8'h80, 32'd23);
    send_item(KIND_BYTE, 8'hFF, 32'd24);
    // printable edges, then a delimiter
    send_item(KIND_BYTE, PRINT_LOW, 32'd100);
    send_item(KIND_BYTE, PRINT_HIGH, 32'd101);
    send_item(KIND_BYTE, 8'h41, 32'd102);
    send_item(KIND_BYTE, DELIM_BYTE, 32'd1000);
    // check exactly at the period (not due), then just past it
    send_item(KIND_TICK, 8'h00, 32'd500000);
    send_item(KIND_TICK, 8'hFF, 32'd500001);
    // due and timed out, then too soon for another check
    send_item(KIND_TICK, 8'h00, 32'd3000002);
    send_item(KIND_TICK, 8'h00, 32'd3000003);
    // message at time zero reads as never seen: no timeout afterwards
    send_item(KIND_BYTE, 8'h7A, 32'd0);
    send_item(KIND_BYTE, DELIM_BYTE, 32'd0);
    send_item(KIND_TICK, 8'h00, 32'd9000000);
    send_item(KIND_TICK, 8'h00, 32'hFFFF_FFFF);
    // silence exactly at the timeout gives nothing, a later tick past it does
    send_item(KIND_BYTE, 8'h6B, 32'd1000000);
    send_item(KIND_BYTE, DELIM_BYTE, 32'd1000000);
    send_item(KIND_TICK, 8'h00, 32'd3000000);
    send_item(KIND_TICK, 8'h00, 32'd3500002);

    // A line that overflows and restarts, then runs past the display width
    clock_us = 32'd4000000;
    send_line(256, 1'b0);
    send_line(30, 1'b1);

    // Random phases: no idling, sender gaps, receiver stalls with one long
    // hold-off, both; register extremes in the second and the last.
    run_phase(32'd1000, 32'd100, 0, 0, 1'b0, 4);
    run_phase(32'd0, 32'd0, 52, 0, 1'b0, 4);
    run_phase(32'd200000, 32'd50000, 0, 52, 1'b1, 12);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 33, 33, 1'b0, 4);

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_null_delimited_message_framer_top

// ===== files.f =====
design/ndmf_pkg.sv
design/null_delimited_message_framer_top.sv
tb/sv/ndmf_result_checker.sv
tb/sv/tb_null_delimited_message_framer_top.sv
